FILE: rtl/fcb_pkg.sv
// Shared constants and round-function helpers for the four-round Feistel cipher.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package fcb_pkg;

   localparam int BLOCK_W     = 32;
   localparam int HALF_W      = BLOCK_W / 2;
   localparam int NIBBLE_W    = 4;
   localparam int NIBBLES     = HALF_W / NIBBLE_W;
   localparam int ROUND_COUNT = 4;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [HALF_W-1:0]  half_type;

   localparam logic [NIBBLE_W-1:0] SBOX [16] = '{
      4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7
   };

   // Four parallel S-box lookups, one per nibble.
   function automatic half_type sbox_layer(input half_type x);
      half_type s;
      s = '0;
      for (int n = 0; n < NIBBLES; n++) begin
         s[n*NIBBLE_W +: NIBBLE_W] = SBOX[x[n*NIBBLE_W +: NIBBLE_W]];
      end
      return s;
   endfunction

   // Bit i moves to bit (13*i + 1) mod 16; pure wiring.
   function automatic half_type bit_perm(input half_type s);
      half_type p;
      p = '0;
      for (int i = 0; i < HALF_W; i++) begin
         p[(13 * i + 1) % HALF_W] = s[i];
      end
      return p;
   endfunction

endpackage

FILE: rtl/fcb_if.sv
// Valid/ready channel interfaces for request, response and key-register write.
// Depends on fcb_pkg for payload widths.
interface fcb_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   fcb_pkg::block_type data_block;
   modport source (output valid, opcode, data_block, input ready);
   modport sink   (input valid, opcode, data_block, output ready);
endinterface

interface fcb_rsp_if;
   logic               valid;
   logic               ready;
   fcb_pkg::block_type result_block;
   modport source (output valid, result_block, input ready);
   modport sink   (input valid, result_block, output ready);
endinterface

interface fcb_csr_if;
   logic               valid;
   logic               ready;
   fcb_pkg::block_type cipher_key;
   modport source (output valid, cipher_key, input ready);
   modport sink   (input valid, cipher_key, output ready);
endinterface

FILE: rtl/fcb_round.sv
// One Feistel round: (L, R) -> (R, L ^ P(S(R ^ k))).
// Depends on fcb_pkg for the S-box and bit permutation.
module fcb_round (
   input  fcb_pkg::half_type left_in,
   input  fcb_pkg::half_type right_in,
   input  fcb_pkg::half_type round_key,
   output fcb_pkg::half_type left_out,
   output fcb_pkg::half_type right_out
);

   fcb_pkg::half_type mix;

   assign mix       = fcb_pkg::bit_perm(fcb_pkg::sbox_layer(right_in ^ round_key));
   assign left_out  = right_in;
   assign right_out = left_in ^ mix;

endmodule

FILE: rtl/fcb_datapath.sv
// Four chained rounds with key schedule selection and the final half swap.
// Depends on fcb_pkg and fcb_round.
module fcb_datapath (
   input  logic               opcode,
   input  fcb_pkg::block_type data_block,
   input  fcb_pkg::block_type cipher_key,
   output fcb_pkg::block_type result_block
);

   fcb_pkg::half_type left  [fcb_pkg::ROUND_COUNT+1];
   fcb_pkg::half_type right [fcb_pkg::ROUND_COUNT+1];
   fcb_pkg::half_type key_hi;
   fcb_pkg::half_type key_lo;
   logic              decrypt;

   assign key_hi   = cipher_key[fcb_pkg::BLOCK_W-1 -: fcb_pkg::HALF_W];
   assign key_lo   = cipher_key[fcb_pkg::HALF_W-1:0];
   assign decrypt  = (opcode == fcb_pkg::OP_DECRYPT);
   assign left[0]  = data_block[fcb_pkg::BLOCK_W-1 -: fcb_pkg::HALF_W];
   assign right[0] = data_block[fcb_pkg::HALF_W-1:0];

   for (genvar r = 0; r < fcb_pkg::ROUND_COUNT; r++) begin : g_round
      // Odd round numbers use the low key half; decrypt walks rounds backward,
      // which flips the parity since the round count is even.
      logic              odd_rnd;
      fcb_pkg::half_type rkey;
      assign odd_rnd = ((r % 2) == 1) ^ decrypt;
      assign rkey    = odd_rnd ? key_lo : key_hi;

      fcb_round u_round (
         .left_in   (left[r]),
         .right_in  (right[r]),
         .round_key (rkey),
         .left_out  (left[r+1]),
         .right_out (right[r+1])
      );
   end

   // Final swap: right half goes on top.
   assign result_block = {right[fcb_pkg::ROUND_COUNT], left[fcb_pkg::ROUND_COUNT]};

endmodule

FILE: rtl/feistel_32bit_block_cipher.sv
// Top level of the four-round 32-bit Feistel cipher: key register, input
// register, round datapath and result register. Depends on fcb_pkg, fcb_if, fcb_datapath.
//
// Usage:
//   csr_if : write transfer loads the 32-bit cipher_key; always ready.
//            Write it only while no block is in flight.
//   req_if : one transfer carries opcode (0 encrypt, 1 decrypt) and a
//            32-bit data_block, left half in bits 31:16.
//   rsp_if : one transfer per request carrying result_block, in order.
// Flow: a block accepted on req_if goes into the input register, runs through
//   all four rounds combinationally, and is loaded into the result register
//   once that slot is free, which raises rsp_if.valid.
// Throughput: one block per cycle; the input and result registers form a
//   two-entry pipeline and a new block is taken every cycle while the
//   response side keeps taking results.
// Stall: when rsp_if.ready is low the result register holds; the input
//   register still fills, so up to two blocks wait before req_if.ready
//   drops. req_if.ready depends combinationally on rsp_if.ready.
// Reset: synchronous, active high; clears both valid flags and the key.
module feistel_32bit_block_cipher (
   input  logic    clock,
   input  logic    reset,
   fcb_req_if.sink   req_if,
   fcb_rsp_if.source rsp_if,
   fcb_csr_if.sink   csr_if
);

   fcb_pkg::block_type key_ff, key_in;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               in_op_ff, in_op_in;
   fcb_pkg::block_type in_blk_ff, in_blk_in;

   // result register
   logic               out_valid_ff, out_valid_in;
   fcb_pkg::block_type out_blk_ff, out_blk_in;

   fcb_pkg::block_type dp_result;
   logic               out_free;
   logic               in_move;
   logic               req_take;

   // key register: the user must write it only while idle; the block does not enforce it
   assign csr_if.ready = 1'b1;
   assign key_in = (csr_if.valid && csr_if.ready) ? csr_if.cipher_key : key_ff;

   fcb_datapath u_datapath (
      .opcode       (in_op_ff),
      .data_block   (in_blk_ff),
      .cipher_key   (key_ff),
      .result_block (dp_result)
   );

   // Result slot frees when empty or its transfer completes this cycle.
   assign out_free     = !out_valid_ff || rsp_if.ready;
   assign in_move      = in_valid_ff && out_free;
   assign req_if.ready = !in_valid_ff || out_free;
   assign req_take     = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_op_in     = in_op_ff;
      in_blk_in    = in_blk_ff;
      out_valid_in = out_valid_ff;
      out_blk_in   = out_blk_ff;

      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
      if (in_move) begin
         out_blk_in = dp_result;
      end

      if (req_take) begin
         in_valid_in = 1'b1;
         in_op_in    = req_if.opcode;
         in_blk_in   = req_if.data_block;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_op_ff   <= in_op_in;
      in_blk_ff  <= in_blk_in;
      out_blk_ff <= out_blk_in;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.result_block = out_blk_ff;

endmodule

FILE: verif/tb.sv
// Self-checking testbench for feistel_32bit_block_cipher: directed and random blocks under
// random back-pressure, checked against a behavioral model of the four-round cipher.
// Depends on rtl/fcb_pkg.sv, rtl/fcb_if.sv and the cipher RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 400;  // cycles with no transfer on any channel
   localparam int SETTLE_TICKS = 4;    // pipeline is two deep; a little margin on top
   localparam int PHASE_ITEMS  = 255;

   // S-box of the round function, nibble in, nibble out
   localparam logic [3:0] SUBST [16] = '{
      4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
      4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7
   };

   typedef struct {
      logic               opcode;
      fcb_pkg::block_type data;
      int unsigned        gap;         // idle cycles before this block is offered
      bit                 wait_drain;  // hold until every outstanding result is back
   } cipher_job_type;

   logic clock = 1'b0;
   logic reset;

   fcb_req_if req_ch ();
   fcb_rsp_if rsp_ch ();
   fcb_csr_if csr_ch ();

   feistel_32bit_block_cipher u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cipher_job_type     jobs_to_send[$];
   fcb_pkg::block_type predicted_blocks[$];
   fcb_pkg::block_type key_shadow;       // key as the cipher holds it
   bit                 send_gaps_on;
   bit                 recv_stalls_on;
   int unsigned        error_count;

   // ---------------------------------------------------------------------------
   // Behavioral model of the cipher
   // ---------------------------------------------------------------------------

   // Round function: key XOR, four S-box lookups, then bit i -> bit (13i+1) mod 16.
   function automatic fcb_pkg::half_type round_mix(input fcb_pkg::half_type rh,
                                                   input fcb_pkg::half_type rkey);
      fcb_pkg::half_type x;
      fcb_pkg::half_type s;
      fcb_pkg::half_type p;
      x = rh ^ rkey;
      for (int n = 0; n < 4; n++) begin
         s[4*n +: 4] = SUBST[x[4*n +: 4]];
      end
      p = '0;
      for (int i = 0; i < 16; i++) begin
         p[(13 * i + 1) % 16] = s[i];
      end
      return p;
   endfunction

   // Four rounds, key halves hi/lo/hi/lo; decrypt walks the schedule backwards.
   // Final half swap on the way out.
   function automatic fcb_pkg::block_type feistel_predict(input logic op,
                                                          input fcb_pkg::block_type blk,
                                                          input fcb_pkg::block_type key);
      fcb_pkg::half_type lh;
      fcb_pkg::half_type rh;
      fcb_pkg::half_type nxt;
      fcb_pkg::half_type rkey;
      int unsigned       idx;
      lh = blk[31:16];
      rh = blk[15:0];
      for (int r = 0; r < fcb_pkg::ROUND_COUNT; r++) begin
         idx  = (op == fcb_pkg::OP_DECRYPT) ? (fcb_pkg::ROUND_COUNT - 1 - r) : r;
         rkey = idx[0] ? key[15:0] : key[31:16];
         nxt  = lh ^ round_mix(rh, rkey);
         lh   = rh;
         rh   = nxt;
      end
      return {rh, lh};
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: pops jobs, honors per-job gaps, holds data until transfer
   // ---------------------------------------------------------------------------
   cipher_job_type cur_job;
   bit             job_held;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid      <= 1'b0;
         req_ch.opcode     <= fcb_pkg::OP_ENCRYPT;
         req_ch.data_block <= '0;
         job_held = 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         // transfer at this edge: record what the cipher must return for it
         if (req_ch.valid) begin
            predicted_blocks.push_back(
               feistel_predict(req_ch.opcode, req_ch.data_block, key_shadow));
         end
         if (!job_held && jobs_to_send.size() != 0) begin
            cur_job  = jobs_to_send.pop_front();
            job_held = 1'b1;
         end
         if (!job_held) begin
            req_ch.valid <= 1'b0;
         end else if (cur_job.gap != 0) begin
            cur_job.gap--;
            req_ch.valid <= 1'b0;
         end else if (cur_job.wait_drain &&
                      (predicted_blocks.size() != 0 || req_ch.valid)) begin
            // sender backs off until the pipeline has emptied completely
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid      <= 1'b1;
            req_ch.opcode     <= cur_job.opcode;
            req_ch.data_block <= cur_job.data;
            job_held = 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor and receiver back-pressure, plus the idle watchdog
   // ---------------------------------------------------------------------------
   int unsigned        stall_left;
   int unsigned        idle_ticks;
   fcb_pkg::block_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
         idle_ticks = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_blocks.size() == 0) begin
               $display("%0t: result with nothing outstanding: got %08h",
                        $time, rsp_ch.result_block);
               error_count++;
            end else begin
               want = predicted_blocks.pop_front();
               if (rsp_ch.result_block !== want) begin
                  $display("%0t: result_block mismatch: expected %08h, got %08h",
                           $time, want, rsp_ch.result_block);
                  error_count++;
               end
            end
            stall_left = recv_stalls_on ? $urandom_range(0, 9) : 0;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end

         // any transfer on any channel counts as progress
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            idle_ticks = 0;
         end else begin
            idle_ticks++;
         end
         if (idle_ticks >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_ticks, predicted_blocks.size());
            $display("FAILURE");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus sequencing
   // ---------------------------------------------------------------------------
   task automatic queue_block(input logic op, input fcb_pkg::block_type data);
      cipher_job_type j;
      j.opcode     = op;
      j.data       = data;
      j.gap        = send_gaps_on ? $urandom_range(0, 9) : 0;
      j.wait_drain = ($urandom_range(0, 199) == 0);
      jobs_to_send.push_back(j);
   endtask

   // Encrypt a block and then decrypt the predicted ciphertext.
   task automatic queue_round_trip(input fcb_pkg::block_type plain);
      queue_block(fcb_pkg::OP_ENCRYPT, plain);
      queue_block(fcb_pkg::OP_DECRYPT,
                  feistel_predict(fcb_pkg::OP_ENCRYPT, plain, key_shadow));
   endtask

   // Key writes only happen with the cipher fully idle.
   task automatic wait_idle();
      while (jobs_to_send.size() != 0 || job_held || req_ch.valid ||
             predicted_blocks.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic load_key(input fcb_pkg::block_type k);
      @(posedge clock);
      csr_ch.valid      <= 1'b1;
      csr_ch.cipher_key <= k;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      key_shadow = k;
   endtask

   task automatic random_phase(input fcb_pkg::block_type k, input bit sgaps,
                               input bit rstalls);
      int unsigned added;
      int unsigned pick;
      wait_idle();
      load_key(k);
      send_gaps_on   = sgaps;
      recv_stalls_on = rstalls;
      added = 0;
      while (added < PHASE_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            queue_round_trip($urandom);
            added += 2;
         end else if (pick == 3) begin
            // edge-heavy data: all-zero or all-one halves
            queue_block(1'($urandom_range(0, 1)),
                        {{16{1'($urandom_range(0, 1))}}, {16{1'($urandom_range(0, 1))}}});
            added++;
         end else begin
            queue_block(1'($urandom_range(0, 1)), $urandom);
            added++;
         end
      end
   endtask

   initial begin
      reset             <= 1'b1;
      csr_ch.valid      <= 1'b0;
      csr_ch.cipher_key <= '0;
      key_shadow     = '0;
      send_gaps_on   = 1'b0;
      recv_stalls_on = 1'b0;
      error_count    = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset key of zero, no idling on either side.
      queue_block(fcb_pkg::OP_ENCRYPT, 32'h0000_0000);
      queue_block(fcb_pkg::OP_DECRYPT, 32'h0000_0000);
      queue_block(fcb_pkg::OP_ENCRYPT, 32'hFFFF_FFFF);
      queue_block(fcb_pkg::OP_DECRYPT, 32'hFFFF_FFFF);
      queue_block(fcb_pkg::OP_ENCRYPT, 32'h0000_FFFF);
      queue_block(fcb_pkg::OP_DECRYPT, 32'hFFFF_0000);
      queue_block(fcb_pkg::OP_ENCRYPT, 32'h0123_4567);
      queue_block(fcb_pkg::OP_DECRYPT, 32'h89AB_CDEF);
      queue_round_trip(32'hAAAA_5555);

      // Directed, all-ones key, both sides idling.
      wait_idle();
      load_key(32'hFFFF_FFFF);
      send_gaps_on   = 1'b1;
      recv_stalls_on = 1'b1;
      queue_block(fcb_pkg::OP_ENCRYPT, 32'h0000_0000);
      queue_block(fcb_pkg::OP_DECRYPT, 32'hFFFF_FFFF);
      queue_block(fcb_pkg::OP_ENCRYPT, 32'h8000_0001);
      queue_block(fcb_pkg::OP_DECRYPT, 32'h0001_8000);
      queue_round_trip(32'hFEDC_BA98);
      queue_round_trip(32'h5555_AAAA);

      // Second block held back until the first one's result is in.
      wait_idle();
      queue_block(fcb_pkg::OP_ENCRYPT, 32'h1357_9BDF);
      queue_block(fcb_pkg::OP_DECRYPT, 32'h2468_ACE0);
      jobs_to_send[1].wait_drain = 1'b1;

      // Random phases, extremes of the key among them.
      random_phase($urandom,          1'b1, 1'b1);
      random_phase(32'h0000_0000,     1'b0, 1'b1);
      random_phase(32'hFFFF_FFFF,     1'b1, 1'b0);
      random_phase(32'hFFFF_0000,     1'b0, 1'b0);
      random_phase(32'h0000_FFFF,     1'b1, 1'b1);
      random_phase($urandom,          1'b1, 1'b1);

      wait_idle();
      if (predicted_blocks.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, predicted_blocks.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/fcb_pkg.sv
rtl/fcb_if.sv
rtl/fcb_round.sv
rtl/fcb_datapath.sv
rtl/feistel_32bit_block_cipher.sv
verif/tb.sv
